/* src/rbt_pkg.sv */
// Shared constants, codes and reset values for the reconnect backoff timer.
package rbt_pkg;

	localparam int MIN_BACKOFF_W  = 16;
	localparam int BACKOFF_W      = 24;
	localparam int ATTEMPT_W      = 8;
	localparam int ACTION_W       = 3;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 24;
	localparam int S_TDATA_W      = 8;
	localparam int S_TUSER_W      = 8;
	localparam int M_FIELDS_W     = 3 + ATTEMPT_W + BACKOFF_W;
	localparam int M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;

	localparam int MAX_SHIFT_DEF  = 5;
	localparam int TIME_WIDTH_DEF = 24;

	localparam logic [MIN_BACKOFF_W-1:0] MIN_BACKOFF_RST  = 16'd1000;
	localparam logic [BACKOFF_W-1:0]     MAX_BACKOFF_RST  = 24'd30000;
	localparam logic [ATTEMPT_W-1:0]     MAX_ATTEMPTS_RST = 8'd10;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK     = 3'd0,
		ACT_SCHEDULE = 3'd1,
		ACT_CANCEL   = 3'd2,
		ACT_RESET    = 3'd3,
		ACT_REACH    = 3'd4
	} action_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_BACKOFF  = 2'd0,
		REG_MAX_BACKOFF  = 2'd1,
		REG_MAX_ATTEMPTS = 2'd2
	} cfg_reg_t;

endpackage

/* src/rbt_backoff.sv */
// Capped exponential backoff: min_backoff shifted by the attempt count, then clamped.
module rbt_backoff #(
	parameter int MAX_SHIFT  = rbt_pkg::MAX_SHIFT_DEF,
	parameter int TIME_WIDTH = rbt_pkg::TIME_WIDTH_DEF
) (
	input  logic [rbt_pkg::ATTEMPT_W-1:0]     attempts,
	input  logic [rbt_pkg::MIN_BACKOFF_W-1:0] min_backoff,
	input  logic [rbt_pkg::BACKOFF_W-1:0]     max_backoff,
	output logic [rbt_pkg::BACKOFF_W-1:0]     backoff
);
	import rbt_pkg::*;

	localparam int SH_W  = $clog2(MAX_SHIFT + 1);
	localparam int SHV_W = MIN_BACKOFF_W + MAX_SHIFT;
	localparam int CMP_W = (SHV_W > BACKOFF_W) ? SHV_W : BACKOFF_W;
	localparam logic [CMP_W-1:0] TIME_LIM = (TIME_WIDTH >= CMP_W) ? {CMP_W{1'b1}} :
		CMP_W'((64'd1 << TIME_WIDTH) - 64'd1);

	logic [SH_W-1:0]  shift;
	logic [CMP_W-1:0] grown;
	logic [CMP_W-1:0] capped;
	logic [CMP_W-1:0] limited;

	always_comb begin
		if (attempts < ATTEMPT_W'(MAX_SHIFT))
			shift = SH_W'(attempts);
		else
			shift = SH_W'(MAX_SHIFT);
		grown  = CMP_W'(min_backoff) << shift;
		capped = (grown > CMP_W'(max_backoff)) ? CMP_W'(max_backoff) : grown;
		limited = (capped > TIME_LIM) ? TIME_LIM : capped;
		backoff = limited[BACKOFF_W-1:0];
	end

endmodule

/* src/reconnect_backoff_timer_top.sv */
// Top level of the reconnect backoff timer with stream ports and a register write port.
// Each transfer on the input stream carries one event (tick, schedule, cancel, reset
// attempts, reachability change) in s_tuser and the online level in s_tdata, and yields
// exactly one result transfer on the output stream. The timer state updates at the
// accepting edge and the result is held in one output register, valid in the cycle after
// acceptance, so the block takes one transfer per cycle as long as the output side
// keeps up. The backoff is min_backoff_ms shifted left by the attempt count (at most
// MAX_SHIFT), capped by max_backoff_ms and by the TIME_WIDTH range. The user must write
// the registers only while no transfer is in flight; the block does not enforce this.
module reconnect_backoff_timer_top #(
	parameter int MAX_SHIFT  = rbt_pkg::MAX_SHIFT_DEF,
	parameter int TIME_WIDTH = rbt_pkg::TIME_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [rbt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rbt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Bit 0 online, the rest zero.
	input  logic [rbt_pkg::S_TDATA_W-1:0]    s_tdata,
	// Bits 2:0 action, the rest zero.
	input  logic [rbt_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Bit 0 reconnect_request, 1 gave_up, 2 pending, 10:3 attempts_done,
	// 34:11 current_backoff_ms, the rest zero.
	output logic [rbt_pkg::M_TDATA_W-1:0]    m_tdata
);
	import rbt_pkg::*;

	localparam int CNT_W = (TIME_WIDTH < BACKOFF_W) ? TIME_WIDTH : BACKOFF_W;

	logic [MIN_BACKOFF_W-1:0] min_backoff_q;
	logic [BACKOFF_W-1:0]     max_backoff_q;
	logic [ATTEMPT_W-1:0]     max_attempts_q;

	logic [ATTEMPT_W-1:0] attempt_q, attempt_d;
	logic [BACKOFF_W-1:0] backoff_q, backoff_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic                 active_q, active_d;
	logic                 waiting_q, waiting_d;

	logic                 fire, gave_up;
	logic                 s_fire;
	logic                 online;
	action_t              action;
	logic [BACKOFF_W-1:0] next_backoff;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign online   = s_tdata[0];
	assign action   = action_t'(s_tuser[ACTION_W-1:0]);
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	rbt_backoff #(
		.MAX_SHIFT  (MAX_SHIFT),
		.TIME_WIDTH (TIME_WIDTH)
	) u_backoff (
		.attempts    (attempt_q),
		.min_backoff (min_backoff_q),
		.max_backoff (max_backoff_q),
		.backoff     (next_backoff)
	);

	always_comb begin
		attempt_d = attempt_q;
		backoff_d = backoff_q;
		count_d   = count_q;
		active_d  = active_q;
		waiting_d = waiting_q;
		fire      = 1'b0;
		gave_up   = 1'b0;
		case (action)
			ACT_TICK: begin
				if (active_q) begin
					if (count_q <= CNT_W'(1)) begin
						count_d  = '0;
						active_d = 1'b0;
						fire     = 1'b1;
					end else begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			ACT_SCHEDULE: begin
				if (attempt_q >= max_attempts_q) begin
					gave_up = 1'b1;
				end else begin
					backoff_d = next_backoff;
					if (attempt_q != {ATTEMPT_W{1'b1}})
						attempt_d = attempt_q + ATTEMPT_W'(1);
					if (!online) begin
						waiting_d = 1'b1;
						active_d  = 1'b0;
						count_d   = '0;
					end else begin
						waiting_d = 1'b0;
						active_d  = 1'b1;
						count_d   = next_backoff[CNT_W-1:0];
					end
				end
			end
			ACT_CANCEL: begin
				active_d  = 1'b0;
				count_d   = '0;
				waiting_d = 1'b0;
				backoff_d = '0;
			end
			ACT_RESET: begin
				attempt_d = '0;
			end
			ACT_REACH: begin
				if (waiting_q && online) begin
					waiting_d = 1'b0;
					active_d  = 1'b1;
					count_d   = backoff_q[CNT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_backoff_q  <= MIN_BACKOFF_RST;
			max_backoff_q  <= MAX_BACKOFF_RST;
			max_attempts_q <= MAX_ATTEMPTS_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MIN_BACKOFF:  min_backoff_q  <= cfg_data[MIN_BACKOFF_W-1:0];
				REG_MAX_BACKOFF:  max_backoff_q  <= cfg_data[BACKOFF_W-1:0];
				REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[ATTEMPT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_q  <= '0;
			backoff_q  <= '0;
			count_q    <= '0;
			active_q   <= 1'b0;
			waiting_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				attempt_q  <= attempt_d;
				backoff_q  <= backoff_d;
				count_q    <= count_d;
				active_q   <= active_d;
				waiting_q  <= waiting_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			m_tdata_q <= M_TDATA_W'({backoff_d, attempt_d, active_d || waiting_d, gave_up, fire});
	end

`ifndef SYNTHESIS
	a_not_armed_and_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		!(active_q && waiting_q))
		else $error("timer armed while waiting for the network");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (count_q == '0))
		else $error("countdown nonzero while the timer is stopped");

	a_cancel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && action == ACT_CANCEL) |=> (!active_q && !waiting_q && backoff_q == '0))
		else $error("cancel did not clear the timer");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> m_tvalid)
		else $error("accepted transfer produced no result");

	a_fire_excludes_giveup: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("reconnect request and give-up in one result");
`endif

endmodule

/* verif/reconnect_backoff_timer_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the reconnect backoff timer, with its own model of the timer.
module reconnect_backoff_timer_top_test;
	import rbt_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int IDLE_PCT      = 38;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 145;
	localparam int HOLD_PHASE    = 2;
	localparam int STEADY_PHASE  = 5;
	localparam int REPORT_MAX    = 10;

	localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic                online;
	} timer_event_t;

	typedef struct packed {
		logic                 fire;
		logic                 gave;
		logic                 pending;
		logic [ATTEMPT_W-1:0] tries;
		logic [BACKOFF_W-1:0] backoff;
	} timer_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wen   = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic [S_TUSER_W-1:0]   s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;

	logic hold_sender = 1'b0;
	logic steady      = 1'b0;
	int   failures    = 0;
	int   cycles      = 0;

	timer_event_t  pending_events[$];
	timer_result_t want_results[$];

	logic [MIN_BACKOFF_W-1:0] base_ms       = MIN_BACKOFF_RST;
	logic [BACKOFF_W-1:0]     ceiling_ms    = MAX_BACKOFF_RST;
	logic [ATTEMPT_W-1:0]     attempt_limit = MAX_ATTEMPTS_RST;
	logic [ATTEMPT_W-1:0]     tries         = '0;
	logic [BACKOFF_W-1:0]     backoff       = '0;
	logic [BACKOFF_W-1:0]     remaining     = '0;
	logic                     armed         = 1'b0;
	logic                     awaiting_link = 1'b0;

	reconnect_backoff_timer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic logic [BACKOFF_W-1:0] grown_backoff();
		int unsigned shift;
		logic [63:0] grown;
		logic [63:0] time_max;
		shift = (tries < MAX_SHIFT_DEF) ? tries : MAX_SHIFT_DEF;
		grown = 64'(base_ms);
		grown = grown << shift;
		time_max = (64'd1 << TIME_WIDTH_DEF) - 64'd1;
		if (grown > {40'd0, ceiling_ms})
			grown = {40'd0, ceiling_ms};
		if (grown > time_max)
			grown = time_max;
		return grown[BACKOFF_W-1:0];
	endfunction

	function automatic void start_countdown(logic online);
		if (!online) begin
			awaiting_link = 1'b1;
			armed = 1'b0;
			remaining = '0;
		end else begin
			awaiting_link = 1'b0;
			remaining = backoff;
			armed = 1'b1;
		end
	endfunction

	function automatic timer_result_t advance_timer(timer_event_t ev);
		timer_result_t res;
		res = '0;
		case (ev.act)
			ACT_TICK: begin
				if (armed) begin
					if (remaining <= 1) begin
						remaining = '0;
						armed = 1'b0;
						res.fire = 1'b1;
					end else begin
						remaining = remaining - 1'b1;
					end
				end
			end
			ACT_SCHEDULE: begin
				if (tries >= attempt_limit) begin
					res.gave = 1'b1;
				end else begin
					backoff = grown_backoff();
					if (tries != '1)
						tries = tries + 1'b1;
					start_countdown(ev.online);
				end
			end
			ACT_CANCEL: begin
				armed = 1'b0;
				remaining = '0;
				awaiting_link = 1'b0;
				backoff = '0;
			end
			ACT_RESET: begin
				tries = '0;
			end
			ACT_REACH: begin
				if (awaiting_link && ev.online)
					start_countdown(ev.online);
			end
			default: begin
			end
		endcase
		res.pending = armed || awaiting_link;
		res.tries = tries;
		res.backoff = backoff;
		return res;
	endfunction

	always @(posedge clk) begin : drive
		logic go;
		timer_event_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				want_results.push_back(advance_timer(pending_events.pop_front()));
			if (!s_tvalid || s_tready) begin
				go = (pending_events.size() != 0) && !hold_sender && !idle_now();
				if (go) begin
					nxt = pending_events[0];
					s_tuser <= {{(S_TUSER_W-ACTION_W){1'b0}}, nxt.act};
					s_tdata <= {{(S_TDATA_W-1){1'b0}}, nxt.online};
				end
				s_tvalid <= go;
			end
		end
	end

	always @(posedge clk) begin : observe
		timer_result_t got;
		timer_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.fire = m_tdata[0];
				got.gave = m_tdata[1];
				got.pending = m_tdata[2];
				got.tries = m_tdata[10:3];
				got.backoff = m_tdata[34:11];
				if (want_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_MAX)
						$display("unexpected result transfer: %h", m_tdata);
				end else begin
					want = want_results.pop_front();
					if (got.fire !== want.fire || got.gave !== want.gave
							|| got.pending !== want.pending || got.tries !== want.tries
							|| got.backoff !== want.backoff) begin
						failures++;
						if (failures <= REPORT_MAX)
							$display({"mismatch: fire %b/%b gave %b/%b pending %b/%b ",
								"attempts %0d/%0d backoff %0d/%0d (expected/actual)"},
								want.fire, got.fire, want.gave, got.gave,
								want.pending, got.pending, want.tries, got.tries,
								want.backoff, got.backoff);
					end
				end
			end
			m_tready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_event(input logic [ACTION_W-1:0] act, input logic online);
		timer_event_t ev;
		ev.act = act;
		ev.online = online;
		pending_events.push_back(ev);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || want_results.size() != 0 || s_tvalid);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] min_v,
			input logic [CFG_DATA_W-1:0] max_v, input logic [CFG_DATA_W-1:0] lim_v);
		put_reg(REG_MIN_BACKOFF, min_v);
		put_reg(REG_MAX_BACKOFF, max_v);
		put_reg(REG_MAX_ATTEMPTS, lim_v);
		@(posedge clk);
		cfg_wen <= 1'b0;
		base_ms = min_v[MIN_BACKOFF_W-1:0];
		ceiling_ms = max_v[BACKOFF_W-1:0];
		attempt_limit = lim_v[ATTEMPT_W-1:0];
		@(negedge clk);
	endtask

	task automatic add_ticks(input int count);
		for (int i = 0; i < count; i++)
			add_event(ACT_TICK, 1'($urandom_range(1)));
	endtask

	// Mostly schedule-then-tick sequences, some offline waits, plus cancels, resets and noise.
	task automatic queue_traffic(input int count);
		int made;
		int pick;
		int len;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			len = ($urandom_range(2) == 0) ? $urandom_range(1, 8) : $urandom_range(8, 70);
			if (pick < 45) begin
				add_event(ACT_SCHEDULE, 1'($urandom_range(9) != 0));
				add_ticks(len);
				made += len + 1;
			end else if (pick < 60) begin
				add_event(ACT_SCHEDULE, 1'b0);
				add_ticks($urandom_range(3));
				add_event(ACT_REACH, 1'b0);
				add_event(ACT_REACH, 1'b1);
				add_ticks(len);
				made += len + 3;
			end else if (pick < 68) begin
				add_event(ACT_CANCEL, 1'($urandom_range(1)));
				made++;
			end else if (pick < 76) begin
				add_event(ACT_RESET, 1'($urandom_range(1)));
				made++;
			end else if (pick < 84) begin
				add_event(ACT_REACH, 1'($urandom_range(1)));
				made++;
			end else begin
				add_event(3'($urandom_range(ACT_SPARE_LAST)), 1'($urandom_range(1)));
				made++;
			end
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] min_v;
		logic [CFG_DATA_W-1:0] max_v;
		logic [CFG_DATA_W-1:0] lim_v;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_event(ACT_TICK, 1'b1);
		add_event(ACT_SPARE_FIRST, 1'b0);
		add_event(ACT_SPARE_FIRST + 3'd1, 1'b1);
		add_event(ACT_SPARE_LAST, 1'b0);
		add_event(ACT_REACH, 1'b1);
		add_event(ACT_SCHEDULE, 1'b1);
		add_event(ACT_SCHEDULE, 1'b1);
		add_event(ACT_CANCEL, 1'b1);
		add_event(ACT_SCHEDULE, 1'b0);
		add_event(ACT_REACH, 1'b0);
		add_event(ACT_TICK, 1'b0);
		add_event(ACT_REACH, 1'b1);
		add_event(ACT_RESET, 1'b1);
		add_event(ACT_CANCEL, 1'b0);
		wait_drained();

		configure('0, 24'hFFFFFF, 24'd2);
		add_event(ACT_SCHEDULE, 1'b1);
		add_event(ACT_TICK, 1'b1);
		add_event(ACT_SCHEDULE, 1'b1);
		add_event(ACT_TICK, 1'b0);
		add_event(ACT_SCHEDULE, 1'b1);
		add_event(ACT_RESET, 1'b0);
		add_event(ACT_SCHEDULE, 1'b0);
		add_event(ACT_REACH, 1'b1);
		add_event(ACT_TICK, 1'b1);
		add_event(ACT_TICK, 1'b1);

		for (int k = 0; k < PHASES; k++) begin
			wait_drained();
			case (k)
				0: configure(24'd65535, 24'hFFFFFF, 24'd255);
				1: configure(24'd1, 24'd1, 24'd0);
				2: configure(24'd1, 24'hFFFFFF, 24'd255);
				3: configure(24'd5, 24'd3, 24'd8);
				default: begin
					if ($urandom_range(9) == 0)
						min_v = '0;
					else if ($urandom_range(19) == 0)
						min_v = CFG_DATA_W'($urandom_range(65535));
					else
						min_v = CFG_DATA_W'($urandom_range(1, 8));
					max_v = ($urandom_range(19) == 0) ? 24'hFFFFFF
						: CFG_DATA_W'($urandom_range(1, 300));
					lim_v = ($urandom_range(9) == 0) ? 24'd255
						: CFG_DATA_W'($urandom_range(0, 12));
					configure(min_v, max_v, lim_v);
				end
			endcase
			steady = (k == STEADY_PHASE);
			queue_traffic(PHASE_ITEMS);
			if (k == HOLD_PHASE) begin
				do
					@(negedge clk);
				while (pending_events.size() > PHASE_ITEMS / 2);
				hold_sender = 1'b1;
				do
					@(negedge clk);
				while (want_results.size() != 0 || s_tvalid);
				hold_sender = 1'b0;
			end
		end

		wait_drained();
		steady = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		failures += want_results.size();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
